@@ rtl/decimal_digit_multiplier_core_macros.svh @@
// Assertion macros for the decimal digit multiplier core.
// Used by decimal_digit_multiplier_core.sv; expects clk_i and rst_ni in scope.
`ifndef DECIMAL_DIGIT_MULTIPLIER_CORE_MACROS_SVH
`define DECIMAL_DIGIT_MULTIPLIER_CORE_MACROS_SVH

// Property checked on every rising edge outside reset
`define DDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising edge, reset included
`define DDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/ddm_pkg.sv @@
// Package for the decimal digit multiplier: field widths, commands, states
// and the divide-by-ten constants. No dependencies.
`default_nettype none

package ddm_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned SUM_W   = 12;   // column sum incl. carry in

  // Largest value a decimal digit may take
  localparam logic [DIGIT_W-1:0] MAX_DIGIT_VAL = 4'd9;

  // Divide by ten: q = (s * RECIP) >> RECIP_SHIFT, exact for s < 2**SUM_W
  localparam int unsigned RECIP_W     = 12;
  localparam int unsigned RECIP_SHIFT = 15;
  localparam logic [RECIP_W-1:0] RECIP = 12'd3277;
  localparam int unsigned QUO_W = SUM_W + RECIP_W - RECIP_SHIFT;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_MULT   = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COL_INIT,
    ST_MAC,
    ST_DRAIN,
    ST_NORM,
    ST_EMIT_TOP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_ZERO
  } state_e;

endpackage

`default_nettype wire

@@ rtl/ddm_in_if.sv @@
// Request channel of the decimal digit multiplier: command and digit.
// Depends on ddm_pkg for the field widths.
`default_nettype none

interface ddm_in_if;
  logic                         valid;
  logic                         ready;
  logic [ddm_pkg::CMD_W-1:0]    command;
  logic [ddm_pkg::DIGIT_W-1:0]  digit;

  modport source (output valid, command, digit, input ready);
  modport sink   (input valid, command, digit, output ready);
endinterface

`default_nettype wire

@@ rtl/ddm_out_if.sv @@
// Result channel of the decimal digit multiplier: product digit and last flag.
// Depends on ddm_pkg for the field widths.
`default_nettype none

interface ddm_out_if;
  logic                         valid;
  logic                         ready;
  logic [ddm_pkg::DIGIT_W-1:0]  product_digit;
  logic                         last_digit;

  modport source (output valid, product_digit, last_digit, input ready);
  modport sink   (input valid, product_digit, last_digit, output ready);
endinterface

`default_nettype wire

@@ rtl/decimal_digit_multiplier_core.sv @@
// Decimal digit multiplier core: operand and column memories with a sequencer.
// Depends on ddm_pkg, ddm_in_if, ddm_out_if and the core macros header.
//
// Usage: requests arrive on in_i. Command LOAD_A / LOAD_B appends a digit
// (most significant first) to operand A / B, one request per cycle while idle;
// a digit above nine or an append to a full operand is dropped. Command MULT
// forms the product and returns its digits on out_o, most significant first,
// with last_digit set on the final one. An empty operand returns a single 0.
// Both operand lengths are cleared by MULT.
// During MULT the column walk reads one digit product per cycle through the
// single read port of each operand memory, with a setup, a drain and a
// divide-by-ten step per column. Each product digit is then read from the
// column memory before it is loaded into the output register; the top carry
// digit needs no read. in_i.ready is low from MULT until its final digit
// is in the output register. out_o is driven from an output register; when
// the receiver stalls, the sequencer holds in its emit states and resumes
// as the register drains. Reset (rst_ni low) clears both lengths and empties
// the output register; no clearing pass.
// Entries of the operand memories are only used below their lengths, and
// writes happen only while idle, so no forwarding is needed.
`default_nettype none

module decimal_digit_multiplier_core #(
  parameter int unsigned MAX_DIGITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ddm_in_if.sink     in_i,
  ddm_out_if.source  out_o
);

  `include "decimal_digit_multiplier_core_macros.svh"

  localparam int unsigned COLS  = 2 * MAX_DIGITS;
  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned COL_W = $clog2(COLS);
  localparam int unsigned CNT_W = COL_W + 1;
  localparam int unsigned DW    = ddm_pkg::DIGIT_W;
  localparam int unsigned SW    = ddm_pkg::SUM_W;
  localparam int unsigned PRD_W = ddm_pkg::SUM_W + ddm_pkg::RECIP_W;

  // Memories
  logic [DW-1:0] mem_a [MAX_DIGITS];
  logic [DW-1:0] mem_b [MAX_DIGITS];
  logic [DW-1:0] mem_c [COLS];

  ddm_pkg::state_e state_q, state_d;
  logic [LEN_W-1:0] len_a_q, len_a_d, len_b_q, len_b_d;
  logic [COL_W-1:0] c_q, c_d, last_col_q, last_col_d;
  logic [IDX_W-1:0] m_q, m_d, m_hi_q, m_hi_d;
  logic [SW-1:0]    acc_q, acc_d, carry_q, carry_d;
  logic             mac_vld_q, mac_vld_d;
  logic             out_vld_q, out_vld_d;
  logic [DW-1:0]    out_digit_q, out_digit_d;
  logic             out_last_q, out_last_d;
  logic [DW-1:0]    a_rd_q, b_rd_q, c_rd_q;

  logic             in_fire, out_free;
  logic             wr_a, wr_b, wr_c;
  logic [IDX_W-1:0] n_idx;
  logic [CNT_W-1:0] la_x, lb_x, c_x, m_lo_x, m_hi_x;
  logic [2*DW-1:0]  prod;
  logic [PRD_W-1:0] recip_prod;
  logic [ddm_pkg::QUO_W-1:0] quo;
  logic [SW-1:0]    quo_ten, rem_full;
  logic [DW-1:0]    rem;

  assign in_i.ready          = (state_q == ddm_pkg::ST_IDLE);
  assign in_fire             = in_i.valid && in_i.ready;
  assign out_free            = !out_vld_q || out_o.ready;
  assign out_o.valid         = out_vld_q;
  assign out_o.product_digit = out_digit_q;
  assign out_o.last_digit    = out_last_q;

  // Appends write the operand memories
  assign wr_a = in_fire && (in_i.command == ddm_pkg::CMD_LOAD_A)
             && (in_i.digit <= ddm_pkg::MAX_DIGIT_VAL)
             && (len_a_q < LEN_W'(MAX_DIGITS));
  assign wr_b = in_fire && (in_i.command == ddm_pkg::CMD_LOAD_B)
             && (in_i.digit <= ddm_pkg::MAX_DIGIT_VAL)
             && (len_b_q < LEN_W'(MAX_DIGITS));
  assign wr_c = (state_q == ddm_pkg::ST_NORM);

  // Product range of the current column c: m in [max(0,c-lb), min(la,c)-1]
  assign la_x   = CNT_W'(len_a_q);
  assign lb_x   = CNT_W'(len_b_q);
  assign c_x    = CNT_W'(c_q);
  assign m_lo_x = (c_x > lb_x) ? (c_x - lb_x) : '0;
  assign m_hi_x = (la_x < c_x) ? (la_x - CNT_W'(1)) : (c_x - CNT_W'(1));
  assign n_idx  = IDX_W'(c_x - CNT_W'(1) - CNT_W'(m_q));

  // Digit product of the data read last cycle
  assign prod = (2*DW)'(a_rd_q) * (2*DW)'(b_rd_q);

  // Divide by ten through a reciprocal
  assign recip_prod = PRD_W'(acc_q) * PRD_W'(ddm_pkg::RECIP);
  assign quo        = recip_prod[ddm_pkg::RECIP_SHIFT +: ddm_pkg::QUO_W];
  assign quo_ten    = (SW'(quo) << 3) + (SW'(quo) << 1);
  assign rem_full   = acc_q - quo_ten;
  assign rem        = rem_full[DW-1:0];

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[len_a_q[IDX_W-1:0]] <= in_i.digit;
    end
    if (wr_b) begin
      mem_b[len_b_q[IDX_W-1:0]] <= in_i.digit;
    end
    if (wr_c) begin
      mem_c[c_q] <= rem;
    end
    a_rd_q <= mem_a[m_q];
    b_rd_q <= mem_b[n_idx];
    c_rd_q <= mem_c[c_q];
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    len_a_d     = len_a_q;
    len_b_d     = len_b_q;
    c_d         = c_q;
    last_col_d  = last_col_q;
    m_d         = m_q;
    m_hi_d      = m_hi_q;
    acc_d       = acc_q;
    carry_d     = carry_q;
    mac_vld_d   = 1'b0;
    out_vld_d   = out_vld_q && !out_o.ready;
    out_digit_d = out_digit_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ddm_pkg::ST_IDLE: begin
        if (wr_a) begin
          len_a_d = len_a_q + LEN_W'(1);
        end
        if (wr_b) begin
          len_b_d = len_b_q + LEN_W'(1);
        end
        if (in_fire && (in_i.command == ddm_pkg::CMD_MULT)) begin
          if ((len_a_q == '0) || (len_b_q == '0)) begin
            len_a_d = '0;
            len_b_d = '0;
            state_d = ddm_pkg::ST_ZERO;
          end else begin
            last_col_d = COL_W'(la_x + lb_x - CNT_W'(1));
            c_d        = COL_W'(la_x + lb_x - CNT_W'(1));
            carry_d    = '0;
            state_d    = ddm_pkg::ST_COL_INIT;
          end
        end
      end
      ddm_pkg::ST_COL_INIT: begin
        m_d     = IDX_W'(m_lo_x);
        m_hi_d  = IDX_W'(m_hi_x);
        acc_d   = carry_q;
        state_d = ddm_pkg::ST_MAC;
      end
      ddm_pkg::ST_MAC: begin
        mac_vld_d = 1'b1;
        if (mac_vld_q) begin
          acc_d = acc_q + SW'(prod);
        end
        if (m_q == m_hi_q) begin
          state_d = ddm_pkg::ST_DRAIN;
        end else begin
          m_d = m_q + IDX_W'(1);
        end
      end
      ddm_pkg::ST_DRAIN: begin
        acc_d   = acc_q + SW'(prod);
        state_d = ddm_pkg::ST_NORM;
      end
      ddm_pkg::ST_NORM: begin
        carry_d = SW'(quo);
        if (c_q == COL_W'(1)) begin
          len_a_d = '0;
          len_b_d = '0;
          state_d = (quo != '0) ? ddm_pkg::ST_EMIT_TOP : ddm_pkg::ST_EMIT_RD;
        end else begin
          c_d     = c_q - COL_W'(1);
          state_d = ddm_pkg::ST_COL_INIT;
        end
      end
      ddm_pkg::ST_EMIT_TOP: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_digit_d = carry_q[DW-1:0];
          out_last_d  = 1'b0;
          state_d     = ddm_pkg::ST_EMIT_RD;
        end
      end
      ddm_pkg::ST_EMIT_RD: begin
        state_d = ddm_pkg::ST_EMIT_LD;
      end
      ddm_pkg::ST_EMIT_LD: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_digit_d = c_rd_q;
          out_last_d  = (c_q == last_col_q);
          if (c_q == last_col_q) begin
            state_d = ddm_pkg::ST_IDLE;
          end else begin
            c_d     = c_q + COL_W'(1);
            state_d = ddm_pkg::ST_EMIT_RD;
          end
        end
      end
      ddm_pkg::ST_ZERO: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_digit_d = '0;
          out_last_d  = 1'b1;
          state_d     = ddm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ddm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ddm_pkg::ST_IDLE;
      len_a_q   <= '0;
      len_b_q   <= '0;
      mac_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_a_q   <= len_a_d;
      len_b_q   <= len_b_d;
      mac_vld_q <= mac_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    c_q         <= c_d;
    last_col_q  <= last_col_d;
    m_q         <= m_d;
    m_hi_q      <= m_hi_d;
    acc_q       <= acc_d;
    carry_q     <= carry_d;
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
  end

  // Assertions
  `DDM_ASSERT(a_len_bound, (len_a_q <= LEN_W'(MAX_DIGITS)) && (len_b_q <= LEN_W'(MAX_DIGITS)), "operand length beyond capacity")
  `DDM_ASSERT(a_mac_range, (state_q == ddm_pkg::ST_MAC) |-> (m_q <= m_hi_q), "product index past column range")
  `DDM_ASSERT(a_mac_src, mac_vld_q |-> ($past(state_q) == ddm_pkg::ST_MAC), "accumulate without a read issued")
  `DDM_ASSERT(a_rem_digit, (state_q == ddm_pkg::ST_NORM) |-> (rem_full < SW'(10)), "divide by ten remainder out of range")
  `DDM_ASSERT(a_emit_cleared, (state_q == ddm_pkg::ST_EMIT_RD) |-> ((len_a_q == '0) && (len_b_q == '0)), "operand lengths not cleared before emission")

endmodule

`default_nettype wire
